### design/tact_pkg.sv
package tact_pkg;

   localparam int MAX_COMMANDS_DEFAULT  = 128;
   localparam int NUM_ACTUATORS_DEFAULT = 5;

   localparam int OP_W      = 3;
   localparam int INDEX_W   = 7;
   localparam int ACT_W     = 3;
   localparam int DUR_W     = 15;
   localparam int PINS_W    = 5;
   localparam int TOTAL_W   = 8;
   localparam int TIME_W    = 32;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
   localparam logic [OP_W-1:0] OP_START    = 3'd1;
   localparam logic [OP_W-1:0] OP_STOP     = 3'd2;
   localparam logic [OP_W-1:0] OP_STOP_ALL = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;
   localparam logic [OP_W-1:0] OP_TICK     = 3'd5;
   localparam logic [OP_W-1:0] OP_CHECK    = 3'd6;

   typedef enum logic [2:0] {
      KIND_ADD,
      KIND_START,
      KIND_STOP,
      KIND_STOP_ALL,
      KIND_CLEAR,
      KIND_TICK,
      KIND_CHECK,
      KIND_IGNORE
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [INDEX_W-1:0]   index;
      logic [ACT_W-1:0]     actuator;
      logic [DUR_W-1:0]     duration_ms;
   } item_type;

endpackage

### design/timed_actuator_command_table.sv
// Timed actuator command table.
// Requests arrive on the req_ channel (valid and stall); each transaction carries an
// op code, an entry index, an actuator number and a duration in milliseconds.
// Every request produces exactly one transaction on the rsp_ channel, in order, with
// the pin levels, whether the op took effect, the active flag of the indexed entry
// and the number of commands held.
// A two-entry request queue sits in front of a sequencer that owns the command
// memories, so requests are taken while a response waits to be collected.
// Add, tick and unused codes go straight to the final read of the indexed entry;
// start and stop first look up and evaluate the entry and may update it.
// Stop all and clear sweep every held entry, and check scans every held entry,
// since the sequencer walks the table at one entry per cycle.
// The sequencer works on one request at a time, so it takes a new one only once
// the response to the last one has been registered.
// Reset empties the table, clears the millisecond counter and drives all pins low;
// no clearing pass is needed, so requests are taken right after reset.
// While the receiver stalls, the response holds; the queue keeps filling and
// req_stall rises once it is full.
module timed_actuator_command_table #(
   parameter int MAX_COMMANDS  = tact_pkg::MAX_COMMANDS_DEFAULT,
   parameter int NUM_ACTUATORS = tact_pkg::NUM_ACTUATORS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tact_pkg::OP_W-1:0]     req_op,
   input  logic [tact_pkg::INDEX_W-1:0]  req_index,
   input  logic [tact_pkg::ACT_W-1:0]    req_actuator,
   input  logic [tact_pkg::DUR_W-1:0]    req_duration_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tact_pkg::PINS_W-1:0]   rsp_pins,
   output logic                          rsp_accepted,
   output logic                          rsp_entry_active,
   output logic [tact_pkg::TOTAL_W-1:0]  rsp_entry_total
);

   logic               q_valid;
   tact_pkg::item_type q_item;
   logic               q_pop;

   tact_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_index       (req_index),
      .req_actuator    (req_actuator),
      .req_duration_ms (req_duration_ms),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   tact_back #(
      .MAX_COMMANDS  (MAX_COMMANDS),
      .NUM_ACTUATORS (NUM_ACTUATORS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pins         (rsp_pins),
      .rsp_accepted     (rsp_accepted),
      .rsp_entry_active (rsp_entry_active),
      .rsp_entry_total  (rsp_entry_total)
   );

endmodule

### design/tact_ram.sv
module tact_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tact_front.sv
module tact_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tact_pkg::OP_W-1:0]     req_op,
   input  logic [tact_pkg::INDEX_W-1:0]  req_index,
   input  logic [tact_pkg::ACT_W-1:0]    req_actuator,
   input  logic [tact_pkg::DUR_W-1:0]    req_duration_ms,
   output logic                          q_valid,
   output tact_pkg::item_type            q_item,
   input  logic                          q_pop
);

   localparam int PTR_W  = (tact_pkg::QUEUE_DEPTH > 1) ? $clog2(tact_pkg::QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(tact_pkg::QUEUE_DEPTH + 1);

   tact_pkg::item_type slot_ff [tact_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   tact_pkg::kind_type kind;
   tact_pkg::item_type item;
   logic               push;
   logic               pop;

   always_comb begin
      case (req_op)
         tact_pkg::OP_ADD:      kind = tact_pkg::KIND_ADD;
         tact_pkg::OP_START:    kind = tact_pkg::KIND_START;
         tact_pkg::OP_STOP:     kind = tact_pkg::KIND_STOP;
         tact_pkg::OP_STOP_ALL: kind = tact_pkg::KIND_STOP_ALL;
         tact_pkg::OP_CLEAR:    kind = tact_pkg::KIND_CLEAR;
         tact_pkg::OP_TICK:     kind = tact_pkg::KIND_TICK;
         tact_pkg::OP_CHECK:    kind = tact_pkg::KIND_CHECK;
         default:               kind = tact_pkg::KIND_IGNORE;
      endcase
   end

   assign item.kind        = kind;
   assign item.index       = req_index;
   assign item.actuator    = req_actuator;
   assign item.duration_ms = req_duration_ms;

   assign req_stall = (fill_ff == FILL_W'(tact_pkg::QUEUE_DEPTH));
   assign q_valid   = (fill_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tact_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tact_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

### design/tact_back.sv
module tact_back #(
   parameter int MAX_COMMANDS  = tact_pkg::MAX_COMMANDS_DEFAULT,
   parameter int NUM_ACTUATORS = tact_pkg::NUM_ACTUATORS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  tact_pkg::item_type            q_item,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tact_pkg::PINS_W-1:0]   rsp_pins,
   output logic                          rsp_accepted,
   output logic                          rsp_entry_active,
   output logic [tact_pkg::TOTAL_W-1:0]  rsp_entry_total
);

   localparam int ADDR_W    = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
   localparam int CNT_W     = $clog2(MAX_COMMANDS + 1);
   localparam int IDX_EXT_W = (ADDR_W > tact_pkg::INDEX_W) ? ADDR_W : tact_pkg::INDEX_W;
   localparam int CMP_W     = (CNT_W > tact_pkg::INDEX_W) ? CNT_W : tact_pkg::INDEX_W;
   localparam int TOT_EXT_W = (CNT_W > tact_pkg::TOTAL_W) ? CNT_W : tact_pkg::TOTAL_W;
   localparam int PIN_EXT_W = (NUM_ACTUATORS > tact_pkg::PINS_W) ?
                              NUM_ACTUATORS : tact_pkg::PINS_W;
   localparam int CMD_W     = tact_pkg::ACT_W + tact_pkg::DUR_W;
   localparam int STAT_W    = 1 + tact_pkg::TIME_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_EVAL,
      S_SWEEP,
      S_CHECK,
      S_FINAL,
      S_DONE
   } state_type;

   state_type                      state_ff;
   tact_pkg::item_type             cur_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [tact_pkg::TIME_W-1:0]    now_ff;
   logic [NUM_ACTUATORS-1:0]       pins_ff;
   logic                           accepted_ff;
   logic [CNT_W-1:0]               scan_ff;
   logic                           pend_ff;
   logic [ADDR_W-1:0]              pend_addr_ff;
   logic                           rsp_valid_ff;
   logic [tact_pkg::PINS_W-1:0]    rsp_pins_ff;
   logic                           rsp_accepted_ff;
   logic                           rsp_entry_active_ff;
   logic [tact_pkg::TOTAL_W-1:0]   rsp_entry_total_ff;

   logic                           cmd_wr_en;
   logic [CMD_W-1:0]               cmd_wr_data;
   logic [CMD_W-1:0]               cmd_rd_data;
   logic                           stat_wr_en;
   logic [STAT_W-1:0]              stat_wr_data;
   logic [STAT_W-1:0]              stat_rd_data;
   logic [ADDR_W-1:0]              wr_addr;
   logic                           rd_en;
   logic [ADDR_W-1:0]              rd_addr;

   logic [IDX_EXT_W-1:0]           idx_ext;
   logic [ADDR_W-1:0]              idx_addr;
   logic                           idx_in_range;
   logic [tact_pkg::ACT_W-1:0]     rd_act;
   logic [tact_pkg::DUR_W-1:0]     rd_dur;
   logic                           rd_active;
   logic [tact_pkg::TIME_W-1:0]    rd_start;
   logic                           usable;
   logic [NUM_ACTUATORS-1:0]       pin_mask;
   logic [tact_pkg::TIME_W-1:0]    elapsed;
   logic                           expire;
   logic                           start_ok;
   logic                           stop_ok;
   logic                           scan_more;
   logic                           add_ok;
   logic                           out_free;
   logic [PIN_EXT_W-1:0]           pins_ext;
   logic [TOT_EXT_W-1:0]           total_ext;

   tact_ram #(.WIDTH(CMD_W), .DEPTH(MAX_COMMANDS)) u_cmd_ram (
      .clock   (clock),
      .wr_en   (cmd_wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (cmd_rd_data)
   );

   tact_ram #(.WIDTH(STAT_W), .DEPTH(MAX_COMMANDS)) u_stat_ram (
      .clock   (clock),
      .wr_en   (stat_wr_en),
      .wr_addr (wr_addr),
      .wr_data (stat_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (stat_rd_data)
   );

   assign idx_ext      = IDX_EXT_W'(cur_ff.index);
   assign idx_addr     = idx_ext[ADDR_W-1:0];
   assign idx_in_range = CMP_W'(cur_ff.index) < CMP_W'(count_ff);

   assign {rd_act, rd_dur}     = cmd_rd_data;
   assign {rd_active, rd_start} = stat_rd_data;

   assign usable = (rd_act != '0) && (rd_act <= tact_pkg::ACT_W'(NUM_ACTUATORS));

   always_comb begin
      for (int k = 0; k < NUM_ACTUATORS; k++) begin
         pin_mask[k] = (rd_act == tact_pkg::ACT_W'(k + 1));
      end
   end

   assign elapsed   = now_ff - rd_start;
   assign expire    = pend_ff && rd_active && (rd_dur != '0) &&
                      (elapsed >= tact_pkg::TIME_W'(rd_dur));
   assign start_ok  = idx_in_range && !rd_active && usable;
   assign stop_ok   = idx_in_range && rd_active;
   assign scan_more = scan_ff < count_ff;
   assign add_ok    = count_ff < CNT_W'(MAX_COMMANDS);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pins_ext  = PIN_EXT_W'(pins_ff);
   assign total_ext = TOT_EXT_W'(count_ff);

   assign q_pop = (state_ff == S_IDLE);

   always_comb begin
      cmd_wr_en    = 1'b0;
      cmd_wr_data  = {q_item.actuator, q_item.duration_ms};
      stat_wr_en   = 1'b0;
      stat_wr_data = '0;
      wr_addr      = idx_addr;
      rd_en        = 1'b0;
      rd_addr      = idx_addr;
      case (state_ff)
         S_IDLE: begin
            wr_addr = count_ff[ADDR_W-1:0];
            if (q_valid && (q_item.kind == tact_pkg::KIND_ADD) && add_ok) begin
               cmd_wr_en  = 1'b1;
               stat_wr_en = 1'b1;
            end
         end
         S_LOOKUP: begin
            rd_en = 1'b1;
         end
         S_EVAL: begin
            if ((cur_ff.kind == tact_pkg::KIND_START) && start_ok) begin
               stat_wr_en   = 1'b1;
               stat_wr_data = {1'b1, now_ff};
            end else if ((cur_ff.kind == tact_pkg::KIND_STOP) && stop_ok) begin
               stat_wr_en   = 1'b1;
               stat_wr_data = {1'b0, rd_start};
            end
         end
         S_SWEEP: begin
            wr_addr    = scan_ff[ADDR_W-1:0];
            stat_wr_en = scan_more;
         end
         S_CHECK: begin
            rd_en        = scan_more;
            rd_addr      = scan_ff[ADDR_W-1:0];
            wr_addr      = pend_addr_ff;
            stat_wr_en   = expire;
            stat_wr_data = {1'b0, rd_start};
         end
         S_FINAL: begin
            rd_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         now_ff       <= '0;
         pins_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cur_ff      <= q_item;
                  accepted_ff <= ((q_item.kind == tact_pkg::KIND_ADD) && add_ok) ||
                                 (q_item.kind == tact_pkg::KIND_TICK);
                  scan_ff     <= '0;
                  pend_ff     <= 1'b0;
                  case (q_item.kind)
                     tact_pkg::KIND_ADD: begin
                        if (add_ok) begin
                           count_ff <= count_ff + 1'b1;
                        end
                        state_ff <= S_FINAL;
                     end
                     tact_pkg::KIND_START,
                     tact_pkg::KIND_STOP: begin
                        state_ff <= S_LOOKUP;
                     end
                     tact_pkg::KIND_STOP_ALL,
                     tact_pkg::KIND_CLEAR: begin
                        state_ff <= S_SWEEP;
                     end
                     tact_pkg::KIND_TICK: begin
                        now_ff   <= now_ff + 1'b1;
                        state_ff <= S_FINAL;
                     end
                     tact_pkg::KIND_CHECK: begin
                        state_ff <= S_CHECK;
                     end
                     default: begin
                        state_ff <= S_FINAL;
                     end
                  endcase
               end
            end
            S_LOOKUP: begin
               state_ff <= S_EVAL;
            end
            S_EVAL: begin
               if ((cur_ff.kind == tact_pkg::KIND_START) && start_ok) begin
                  pins_ff     <= pins_ff | pin_mask;
                  accepted_ff <= 1'b1;
               end else if ((cur_ff.kind == tact_pkg::KIND_STOP) && stop_ok) begin
                  pins_ff     <= pins_ff & ~pin_mask;
                  accepted_ff <= 1'b1;
               end
               state_ff <= S_FINAL;
            end
            S_SWEEP: begin
               if (scan_more) begin
                  scan_ff <= scan_ff + 1'b1;
               end else begin
                  pins_ff     <= '0;
                  accepted_ff <= 1'b1;
                  if (cur_ff.kind == tact_pkg::KIND_CLEAR) begin
                     count_ff <= '0;
                  end
                  state_ff <= S_FINAL;
               end
            end
            S_CHECK: begin
               pend_ff      <= scan_more;
               pend_addr_ff <= scan_ff[ADDR_W-1:0];
               if (scan_more) begin
                  scan_ff <= scan_ff + 1'b1;
               end
               if (expire) begin
                  pins_ff <= pins_ff & ~pin_mask;
               end
               if (!scan_more && !pend_ff) begin
                  accepted_ff <= 1'b1;
                  state_ff    <= S_FINAL;
               end
            end
            S_FINAL: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_pins_ff         <= pins_ext[tact_pkg::PINS_W-1:0];
                  rsp_accepted_ff     <= accepted_ff;
                  rsp_entry_active_ff <= idx_in_range && rd_active;
                  rsp_entry_total_ff  <= total_ext[tact_pkg::TOTAL_W-1:0];
                  state_ff            <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pins         = rsp_pins_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_entry_active = rsp_entry_active_ff;
   assign rsp_entry_total  = rsp_entry_total_ff;

endmodule

### design/tact_checker.sv
module tact_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [tact_pkg::PINS_W-1:0]   rsp_pins,
   input  logic                          rsp_accepted,
   input  logic                          rsp_entry_active,
   input  logic [tact_pkg::TOTAL_W-1:0]  rsp_entry_total
);

   localparam int MAX_INFLIGHT = tact_pkg::QUEUE_DEPTH + 2;
   localparam int FLIGHT_W     = $clog2(MAX_INFLIGHT + 1) + 1;

   logic                req_take;
   logic                rsp_take;
   logic [FLIGHT_W-1:0] inflight_ff;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else if (req_take && !rsp_take) begin
         inflight_ff <= inflight_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         inflight_ff <= inflight_ff - 1'b1;
      end
   end

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pins) && $stable(rsp_accepted) &&
                                 $stable(rsp_entry_active) && $stable(rsp_entry_total);
   endproperty

   a_rsp_hold: assert property (p_rsp_hold)
      else $error("response changed while stalled");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
                                 rsp_valid |-> inflight_ff != '0)
      else $error("response without an outstanding request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
                               inflight_ff <= FLIGHT_W'(MAX_INFLIGHT))
      else $error("more transactions in flight than the block can hold");

endmodule

bind timed_actuator_command_table tact_checker u_checker (.*);

### tb/tb_timed_actuator_command_table.sv
`timescale 1ns / 1ps

module tb_timed_actuator_command_table;
   import tact_pkg::*;

   localparam int TABLE_SIZE = MAX_COMMANDS_DEFAULT;
   localparam int ACTUATORS = NUM_ACTUATORS_DEFAULT;
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
   localparam int RANDOM_ITEMS = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [PINS_W-1:0]  pins;
      logic               accepted;
      logic               entry_active;
      logic [TOTAL_W-1:0] entry_total;
   } rsp_fields_t;

   class actuator_scoreboard;
      logic [ACT_W-1:0]  act_mem[TABLE_SIZE];
      logic [DUR_W-1:0]  dur_mem[TABLE_SIZE];
      logic [TIME_W-1:0] start_mem[TABLE_SIZE];
      bit                running[TABLE_SIZE];
      int                held;
      logic [TIME_W-1:0] now_ms;
      logic [PINS_W-1:0] pin_state;
      rsp_fields_t       expected_q[$];
      int                mismatches;
      int                compared;
      int                op_seen[8];

      function new();
         held = 0;
         now_ms = '0;
         pin_state = '0;
         mismatches = 0;
         compared = 0;
         foreach (running[i]) running[i] = 1'b0;
         foreach (op_seen[i]) op_seen[i] = 0;
      endfunction

      function bit usable(logic [ACT_W-1:0] a);
         return a >= 1 && a <= ACTUATORS;
      endfunction

      function logic [PINS_W-1:0] pin_mask(logic [ACT_W-1:0] a);
         return PINS_W'(1) << (a - 1);
      endfunction

      function bit halt_entry(int i);
         if (i >= held || !running[i]) return 1'b0;
         if (usable(act_mem[i])) pin_state &= ~pin_mask(act_mem[i]);
         running[i] = 1'b0;
         return 1'b1;
      endfunction

      function void halt_all();
         for (int i = 0; i < held; i++) void'(halt_entry(i));
         pin_state = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                                 logic [ACT_W-1:0] act, logic [DUR_W-1:0] dur);
         rsp_fields_t r;
         bit ok;
         ok = 1'b0;
         op_seen[op]++;
         case (op)
            OP_ADD: begin
               if (held < TABLE_SIZE) begin
                  act_mem[held] = act;
                  dur_mem[held] = dur;
                  running[held] = 1'b0;
                  start_mem[held] = '0;
                  held++;
                  ok = 1'b1;
               end
            end
            OP_START: begin
               if (idx < held && !running[idx] && usable(act_mem[idx])) begin
                  pin_state |= pin_mask(act_mem[idx]);
                  running[idx] = 1'b1;
                  start_mem[idx] = now_ms;
                  ok = 1'b1;
               end
            end
            OP_STOP: ok = halt_entry(idx);
            OP_STOP_ALL: begin
               halt_all();
               ok = 1'b1;
            end
            OP_CLEAR: begin
               halt_all();
               held = 0;
               ok = 1'b1;
            end
            OP_TICK: begin
               now_ms = now_ms + 1;
               ok = 1'b1;
            end
            OP_CHECK: begin
               for (int i = 0; i < held; i++) begin
                  if (running[i] && dur_mem[i] != 0 &&
                      (now_ms - start_mem[i]) >= TIME_W'(dur_mem[i]))
                     void'(halt_entry(i));
               end
               ok = 1'b1;
            end
            default: ok = 1'b0;
         endcase
         r.pins = pin_state;
         r.accepted = ok;
         r.entry_active = (idx < held) && running[idx];
         r.entry_total = TOTAL_W'(held);
         expected_q.push_back(r);
      endfunction

      function void check_response(rsp_fields_t got);
         rsp_fields_t exp;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with nothing expected: pins=%b acc=%b act=%b total=%0d",
                        $realtime, got.pins, got.accepted, got.entry_active, got.entry_total);
            return;
         end
         exp = expected_q.pop_front();
         compared++;
         if (got.pins !== exp.pins || got.accepted !== exp.accepted ||
             got.entry_active !== exp.entry_active || got.entry_total !== exp.entry_total) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch on response %0d: exp pins=%b acc=%b act=%b total=%0d, got pins=%b acc=%b act=%b total=%0d",
                        $realtime, compared, exp.pins, exp.accepted, exp.entry_active,
                        exp.entry_total, got.pins, got.accepted, got.entry_active,
                        got.entry_total);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_op;
   logic [INDEX_W-1:0]  req_index;
   logic [ACT_W-1:0]    req_actuator;
   logic [DUR_W-1:0]    req_duration_ms;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [PINS_W-1:0]   rsp_pins;
   logic                rsp_accepted;
   logic                rsp_entry_active;
   logic [TOTAL_W-1:0]  rsp_entry_total;

   actuator_scoreboard sb;
   int sent_count = 0;
   int receiver_hold = 0;
   int idle_cycles = 0;
   bit fast_stretch = 1'b0;

   timed_actuator_command_table dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_index(req_index),
      .req_actuator(req_actuator),
      .req_duration_ms(req_duration_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pins(rsp_pins),
      .rsp_accepted(rsp_accepted),
      .rsp_entry_active(rsp_entry_active),
      .rsp_entry_total(rsp_entry_total)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_op, req_index, req_actuator, req_duration_ms);
         if (rsp_valid && !rsp_stall)
            sb.check_response({rsp_pins, rsp_accepted, rsp_entry_active, rsp_entry_total});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int hold;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (receiver_hold > 0) begin
            hold = receiver_hold;
            receiver_hold = 0;
         end else begin
            hold = fast_stretch ? 0 : $urandom_range(0, 3);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   function automatic logic [INDEX_W-1:0] pick_index();
      if ($urandom_range(0, 4) == 0 || sb.held == 0) return INDEX_W'($urandom);
      return INDEX_W'($urandom_range(0, sb.held - 1));
   endfunction

   function automatic logic [ACT_W-1:0] pick_actuator();
      if ($urandom_range(0, 6) == 0) return ACT_W'($urandom);
      return ACT_W'($urandom_range(1, ACTUATORS));
   endfunction

   function automatic logic [DUR_W-1:0] pick_duration();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return DUR_W'($urandom);
      if (r < 3) return '0;
      return DUR_W'($urandom_range(1, 6));
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                               input logic [ACT_W-1:0] act, input logic [DUR_W-1:0] dur);
      int gap;
      gap = fast_stretch ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_index <= idx;
      req_actuator <= act;
      req_duration_ms <= dur;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic run_program();
      int r;
      logic [OP_W-1:0] op;
      if ($urandom_range(0, 3) == 0)
         send_request(OP_CLEAR, pick_index(), pick_actuator(), pick_duration());
      repeat ($urandom_range(1, 8))
         send_request(OP_ADD, INDEX_W'($urandom), pick_actuator(), pick_duration());
      repeat ($urandom_range(10, 30)) begin
         r = $urandom_range(0, 99);
         if (r < 30) op = OP_START;
         else if (r < 55) op = OP_TICK;
         else if (r < 75) op = OP_CHECK;
         else if (r < 88) op = OP_STOP;
         else if (r < 92) op = OP_ADD;
         else if (r < 95) op = OP_STOP_ALL;
         else if (r < 97) op = OP_CLEAR;
         else op = OP_UNUSED;
         send_request(op, pick_index(), pick_actuator(), pick_duration());
      end
   endtask

   task automatic run_full_table();
      send_request(OP_CLEAR, '0, '0, '0);
      repeat (TABLE_SIZE + 3)
         send_request(OP_ADD, INDEX_W'($urandom), pick_actuator(), pick_duration());
      send_request(OP_START, 7'd127, '0, '0);
      send_request(OP_START, 7'd120, '0, '0);
      send_request(OP_START, 7'd64, '0, '0);
      repeat (3) send_request(OP_TICK, pick_index(), '0, '0);
      send_request(OP_CHECK, 7'd120, '0, '0);
      send_request(OP_STOP, 7'd127, '0, '0);
      send_request(OP_STOP_ALL, 7'd64, '0, '0);
      send_request(OP_CLEAR, '0, '0, '0);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(negedge clock);
   endtask

   initial begin
      int directed_n;
      bit hold_done;
      bit pause_done;
      bit fill_done;
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = '0;
      req_index = '0;
      req_actuator = '0;
      req_duration_ms = '0;
      rsp_stall = 1'b0;
      hold_done = 1'b0;
      pause_done = 1'b0;
      fill_done = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(OP_CHECK, '0, '0, '0);
      send_request(OP_STOP_ALL, '0, '0, '0);
      send_request(OP_START, 7'd127, 3'd7, 15'h7fff);
      send_request(OP_UNUSED, 7'd127, 3'd7, 15'h7fff);
      send_request(OP_ADD, '0, 3'd1, 15'd0);
      send_request(OP_ADD, 7'd127, 3'd5, 15'h7fff);
      send_request(OP_ADD, '0, 3'd0, 15'd3);
      send_request(OP_ADD, '0, 3'd7, 15'd2);
      send_request(OP_ADD, '0, 3'd1, 15'd2);
      send_request(OP_ADD, '0, 3'd3, 15'd1);
      send_request(OP_START, 7'd0, '0, '0);
      send_request(OP_START, 7'd0, '0, '0);
      send_request(OP_START, 7'd2, '0, '0);
      send_request(OP_START, 7'd3, '0, '0);
      send_request(OP_START, 7'd4, '0, '0);
      send_request(OP_START, 7'd5, '0, '0);
      send_request(OP_START, 7'd1, '0, '0);
      send_request(OP_TICK, 7'd5, '0, '0);
      send_request(OP_CHECK, 7'd5, '0, '0);
      send_request(OP_TICK, 7'd4, '0, '0);
      send_request(OP_CHECK, 7'd0, '0, '0);
      send_request(OP_STOP, 7'd0, '0, '0);
      send_request(OP_STOP, 7'd0, '0, '0);
      send_request(OP_STOP, 7'd127, '0, '0);
      send_request(OP_STOP_ALL, 7'd1, '0, '0);
      send_request(OP_CLEAR, 7'd1, '0, '0);
      directed_n = sent_count;

      while (sent_count < directed_n + RANDOM_ITEMS) begin
         if (!hold_done && sent_count > directed_n + 60) begin
            receiver_hold = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (!fill_done && sent_count > directed_n + 120) begin
            run_full_table();
            fill_done = 1'b1;
         end
         if (!pause_done && sent_count > directed_n + 280) begin
            pause_until_drained();
            pause_done = 1'b1;
         end
         if ($urandom_range(0, 5) == 0) fast_stretch = ~fast_stretch;
         if ($urandom_range(0, 9) < 8) begin
            run_program();
         end else begin
            repeat (10)
               send_request(OP_W'($urandom), INDEX_W'($urandom), ACT_W'($urandom),
                            DUR_W'($urandom));
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d requests: add %0d, start %0d, stop %0d, stop all %0d, clear %0d",
               sent_count, sb.op_seen[OP_ADD], sb.op_seen[OP_START], sb.op_seen[OP_STOP],
               sb.op_seen[OP_STOP_ALL], sb.op_seen[OP_CLEAR]);
      $display("tick %0d, check %0d, unused code %0d; %0d responses compared, %0d mismatches",
               sb.op_seen[OP_TICK], sb.op_seen[OP_CHECK], sb.op_seen[OP_UNUSED],
               sb.compared, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### timed_actuator_command_table.f
design/tact_pkg.sv
design/tact_ram.sv
design/tact_front.sv
design/tact_back.sv
design/timed_actuator_command_table.sv
design/tact_checker.sv
tb/tb_timed_actuator_command_table.sv
